### rtl/swof_pkg.sv
// swof_pkg: shared types and constants for the sliding window weighted order filter
// used by swof_cell, swof_mac and sliding_window_weighted_order_filter
// no dependencies
package swof_pkg;

    localparam int WINDOW      = 9;
    localparam int MAX_WEIGHTS = 5;
    localparam int FRAC_BITS   = 14;
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int AGE_W       = $clog2(WINDOW);
    localparam int POS_W       = $clog2(WINDOW);
    localparam int SEL_W       = $clog2(WINDOW + MAX_WEIGHTS);
    localparam int HALF        = WINDOW / 2;
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W + $clog2(MAX_WEIGHTS);
    localparam int SHIFT_W     = SUM_W - FRAC_BITS;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WEIGHTS_IN_USE = 3'd0,
        CFG_WEIGHT_0       = 3'd1,
        CFG_WEIGHT_1       = 3'd2,
        CFG_WEIGHT_2       = 3'd3,
        CFG_WEIGHT_3       = 3'd4,
        CFG_WEIGHT_4       = 3'd5
    } cfg_index_t;

    // one sorted slot: sample value and how many transfers ago it arrived
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [AGE_W-1:0]    age;
    } entry_t;

    typedef struct packed {
        logic               load;
        logic [COUNT_W-1:0] count;
    } mac_ctrl_t;

endpackage

### rtl/swof_cell.sv
// swof_cell: one slot of the sorted window; drops the oldest entry and inserts the
// new sample using only its neighbors and a ripple of the "oldest seen" flag
// depends on swof_pkg
module swof_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 update,
    input  logic signed [swof_pkg::SAMPLE_W-1:0] x,
    input  swof_pkg::entry_t                     left,
    input  swof_pkg::entry_t                     right,
    input  logic                                 has_left,
    input  logic                                 is_last,
    input  logic [swof_pkg::AGE_W-1:0]           init_age,
    input  logic                                 gone_in,
    output logic                                 gone_out,
    output swof_pkg::entry_t                     entry
);

    swof_pkg::entry_t entry_reg;
    swof_pkg::entry_t entry_next;
    swof_pkg::entry_t c_prev;
    swof_pkg::entry_t c_here;
    logic             oldest;

    assign oldest   = (entry_reg.age == swof_pkg::AGE_W'(swof_pkg::WINDOW - 1));
    assign gone_out = gone_in | oldest;

    // compacted list after the oldest entry is removed
    assign c_prev = gone_in  ? entry_reg : left;
    assign c_here = gone_out ? right     : entry_reg;

    always_comb
    begin
        priority if (has_left && ($signed(c_prev.value) > x))
        begin
            entry_next.value = c_prev.value;
            entry_next.age   = c_prev.age + swof_pkg::AGE_W'(1);
        end
        else if (is_last || ($signed(c_here.value) > x))
        begin
            entry_next.value = x;
            entry_next.age   = '0;
        end
        else
        begin
            entry_next.value = c_here.value;
            entry_next.age   = c_here.age + swof_pkg::AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.value <= '0;
            entry_reg.age   <= init_age;
        end
        else if (update)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

### rtl/swof_mac.sv
// swof_mac: picks the central sorted values, registers the weighted products,
// then sums, floor-shifts by the fraction width and saturates to 16 bits
// depends on swof_pkg
module swof_mac (
    input  logic                                 clk,
    input  swof_pkg::mac_ctrl_t                  ctrl,
    input  logic [swof_pkg::SAMPLE_W-1:0]        sorted [swof_pkg::WINDOW],
    input  logic [swof_pkg::WEIGHT_W-1:0]        weights [swof_pkg::MAX_WEIGHTS],
    output logic signed [swof_pkg::SAMPLE_W-1:0] result
);

    logic [swof_pkg::COUNT_W-1:0]        count_eff;
    logic [swof_pkg::SEL_W-1:0]          start;
    logic signed [swof_pkg::PROD_W-1:0]  prod_reg  [swof_pkg::MAX_WEIGHTS];
    logic signed [swof_pkg::PROD_W-1:0]  prod_next [swof_pkg::MAX_WEIGHTS];
    logic signed [swof_pkg::SUM_W-1:0]   sum;
    logic signed [swof_pkg::SHIFT_W-1:0] shifted;

    always_comb
    begin
        if (ctrl.count == '0)
            count_eff = swof_pkg::COUNT_W'(1);
        else if (ctrl.count > swof_pkg::COUNT_W'(swof_pkg::MAX_WEIGHTS))
            count_eff = swof_pkg::COUNT_W'(swof_pkg::MAX_WEIGHTS);
        else
            count_eff = ctrl.count;
        start = swof_pkg::SEL_W'(swof_pkg::HALF)
              - swof_pkg::SEL_W'((count_eff - swof_pkg::COUNT_W'(1)) >> 1);
    end

    always_comb
    begin
        logic [swof_pkg::SEL_W-1:0] idx;
        for (int k = 0; k < swof_pkg::MAX_WEIGHTS; k++)
        begin
            idx = start + swof_pkg::SEL_W'(k);
            if ((swof_pkg::COUNT_W'(k) < count_eff) && (idx < swof_pkg::SEL_W'(swof_pkg::WINDOW)))
                prod_next[k] = $signed(weights[k])
                             * $signed(sorted[idx[swof_pkg::POS_W-1:0]]);
            else
                prod_next[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int k = 0; k < swof_pkg::MAX_WEIGHTS; k++)
                prod_reg[k] <= prod_next[k];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < swof_pkg::MAX_WEIGHTS; k++)
            sum = sum + swof_pkg::SUM_W'(prod_reg[k]);
        // arithmetic shift floors toward minus infinity
        shifted = swof_pkg::SHIFT_W'(sum >>> swof_pkg::FRAC_BITS);
        if (shifted > swof_pkg::SHIFT_W'(32767))
            result = 16'sh7fff;
        else if (shifted < -swof_pkg::SHIFT_W'(32768))
            result = 16'sh8000;
        else
            result = shifted[swof_pkg::SAMPLE_W-1:0];
    end

endmodule

### rtl/sliding_window_weighted_order_filter.sv
// sliding_window_weighted_order_filter: top level, config registers, sorted cell
// row, pipeline control and output register
// depends on swof_pkg, swof_cell, swof_mac
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid, in_ready, sample           | in
//  output   | out_valid, out_ready, filtered       | out
//  config   | cfg_we, cfg_index, cfg_data          | in
//
// one sample per cycle sustained while the output is not stalled; the cell row re-sorts
// in the transfer cycle; a sample passes the cell, product and output registers in turn
// reset sets the window to zeros and the weights to a plain median
// a stalled output freezes the whole pipe, and in_ready drops with it
module sliding_window_weighted_order_filter (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [swof_pkg::SAMPLE_W-1:0]    sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [swof_pkg::SAMPLE_W-1:0]    filtered,
    input  logic                                    cfg_we,
    input  logic [swof_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [swof_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int W = swof_pkg::WINDOW;

    logic [swof_pkg::COUNT_W-1:0]  count_reg;
    logic [swof_pkg::WEIGHT_W-1:0] weight_reg [swof_pkg::MAX_WEIGHTS];
    logic                          fresh_reg;
    logic                          prod_valid_reg;
    logic                          out_valid_reg;
    logic signed [swof_pkg::SAMPLE_W-1:0] filtered_reg;
    logic                          advance;
    logic                          accept;
    swof_pkg::entry_t              entries [W];
    logic                          gone [W+1];
    logic [swof_pkg::SAMPLE_W-1:0] sorted [W];
    logic [W-1:0]                  oldest_vec;
    logic [W-1:0]                  sorted_ok;
    swof_pkg::mac_ctrl_t           mac_ctrl;
    logic signed [swof_pkg::SAMPLE_W-1:0] mac_result;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= swof_pkg::COUNT_W'(1);
            for (int k = 0; k < swof_pkg::MAX_WEIGHTS; k++)
                weight_reg[k] <= (k == 0) ? swof_pkg::WEIGHT_W'(16384) : '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swof_pkg::CFG_WEIGHTS_IN_USE: count_reg     <= cfg_data[swof_pkg::COUNT_W-1:0];
                swof_pkg::CFG_WEIGHT_0:       weight_reg[0] <= cfg_data;
                swof_pkg::CFG_WEIGHT_1:       weight_reg[1] <= cfg_data;
                swof_pkg::CFG_WEIGHT_2:       weight_reg[2] <= cfg_data;
                swof_pkg::CFG_WEIGHT_3:       weight_reg[3] <= cfg_data;
                swof_pkg::CFG_WEIGHT_4:       weight_reg[4] <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // sorted cell row
    assign gone[0] = 1'b0;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        swof_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .update   (accept),
            .x        (sample),
            .left     ((i == 0) ? entries[i] : entries[(i == 0) ? 0 : i - 1]),
            .right    ((i == W - 1) ? entries[i] : entries[(i == W - 1) ? i : i + 1]),
            .has_left (i != 0),
            .is_last  (i == W - 1),
            .init_age (swof_pkg::AGE_W'(W - 1 - i)),
            .gone_in  (gone[i]),
            .gone_out (gone[i+1]),
            .entry    (entries[i])
        );
        assign sorted[i]     = entries[i].value;
        assign oldest_vec[i] = (entries[i].age == swof_pkg::AGE_W'(W - 1));
        if (i == 0)
        begin : g_first
            assign sorted_ok[i] = 1'b1;
        end
        else
        begin : g_rest
            assign sorted_ok[i] = $signed(entries[i-1].value) <= $signed(entries[i].value);
        end
    end

    assign mac_ctrl.load  = advance && fresh_reg;
    assign mac_ctrl.count = count_reg;

    swof_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .sorted  (sorted),
        .weights (weight_reg),
        .result  (mac_result)
    );

    // pipeline valid bits, all moving together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg      <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            fresh_reg      <= accept;
            prod_valid_reg <= fresh_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && prod_valid_reg)
            filtered_reg <= mac_result;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // exactly one entry is due for eviction
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(oldest_vec))
        else $error("cell row does not hold exactly one oldest entry");

    a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &sorted_ok)
        else $error("cell row out of order");

    a_fresh_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> fresh_reg)
        else $error("transfer did not mark the cell row fresh");

    a_output_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && prod_valid_reg) |=> out_valid_reg)
        else $error("products lost before the output register");

endmodule
